// File: rtl/cfcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cfcd_pkg;

  localparam int unsigned INDEX_WIDTH_DEF  = 48;
  localparam int unsigned WINDOW_WIDTH_DEF = 24;

  localparam int unsigned RATE_W     = 30;
  localparam int unsigned WIN_REG_W  = 24;
  localparam int unsigned TOL_W      = 16;
  localparam int unsigned FREQ_W     = 37;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned CFG_DATA_W = 30;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned QUEUE_DEPTH = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd2;

  // command codes
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  localparam logic signed [SAMPLE_W-1:0] HIGH_THRESHOLD = 16'sd8192;

  localparam logic [RATE_W-1:0]    RATE_RESET   = 30'd1000000;
  localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 24'd0;
  localparam logic [TOL_W-1:0]     TOL_RESET    = 16'd1311;

  // rate / 1000 as (rate * ceil(2^40 / 1000)) >> 40, exact for 30-bit rates
  localparam int unsigned          RECIP_W     = 31;
  localparam int unsigned          RECIP_SHIFT = 40;
  localparam logic [RECIP_W-1:0]   RATE_RECIP  = 31'd1099511628;

  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

endpackage

`default_nettype wire

// File: rtl/clock_frequency_change_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                 Payload
// input     in_valid_i / in_stall_o   cmd_i, sample_i, sample_index_i
// output    out_valid_o / out_stall_i window_start_o, frequency_q8_o
// config    cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// The front end takes one transaction per cycle while the window job queue
// (QUEUE_DEPTH entries) has room. Each window end takes the back end through
// multiply, one quotient bit per cycle in the divider, tolerance check and
// result load; the back end pops the next job only from idle.
// After reset, and after a write to the sample rate or window register, the
// input stalls while the window length settles.
// A stalled result holds the back end in its decision step; the front end
// keeps running until the queue fills.

module clock_frequency_change_detector #(
  parameter int unsigned INDEX_WIDTH  = cfcd_pkg::INDEX_WIDTH_DEF,
  parameter int unsigned WINDOW_WIDTH = cfcd_pkg::WINDOW_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic signed [cfcd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [INDEX_WIDTH-1:0]              sample_index_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [INDEX_WIDTH-1:0]              window_start_o,
  output logic [cfcd_pkg::FREQ_W-1:0]         frequency_q8_o,
  input  logic                                cfg_we_i,
  input  logic [cfcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cfcd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import cfcd_pkg::*;

  localparam int unsigned JOB_W = 1 + WINDOW_WIDTH + INDEX_WIDTH;

  logic [RATE_W-1:0]       rate;
  logic [TOL_W-1:0]        tol;
  logic [WINDOW_WIDTH-1:0] win_len;
  logic                    cfg_busy, cfg_clear;
  logic                    q_push, q_pop, q_full, q_empty;
  logic                    f_clr, b_clr;
  logic [WINDOW_WIDTH-1:0] f_edges, b_edges;
  logic [INDEX_WIDTH-1:0]  f_start, b_start;
  logic [JOB_W-1:0]        q_wdata, q_rdata;

  cfcd_cfg #(.WINDOW_WIDTH(WINDOW_WIDTH)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .rate_o      (rate),
    .tol_o       (tol),
    .win_len_o   (win_len),
    .busy_o      (cfg_busy),
    .clear_o     (cfg_clear)
  );

  cfcd_front #(.INDEX_WIDTH(INDEX_WIDTH), .WINDOW_WIDTH(WINDOW_WIDTH)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .sample_i       (sample_i),
    .sample_index_i (sample_index_i),
    .win_len_i      (win_len),
    .cfg_busy_i     (cfg_busy),
    .cfg_clear_i    (cfg_clear),
    .q_full_i       (q_full),
    .q_push_o       (q_push),
    .job_clr_o      (f_clr),
    .job_edges_o    (f_edges),
    .job_start_o    (f_start)
  );

  assign q_wdata = {f_clr, f_edges, f_start};
  assign {b_clr, b_edges, b_start} = q_rdata;

  cfcd_fifo #(.DATA_W(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  cfcd_back #(.INDEX_WIDTH(INDEX_WIDTH), .WINDOW_WIDTH(WINDOW_WIDTH)) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .job_clr_i      (b_clr),
    .job_edges_i    (b_edges),
    .job_start_i    (b_start),
    .rate_i         (rate),
    .tol_i          (tol),
    .win_len_i      (win_len),
    .cfg_clear_i    (cfg_clear),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_start_o (window_start_o),
    .frequency_q8_o (frequency_q8_o)
  );

endmodule

`default_nettype wire

// File: rtl/cfcd_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module cfcd_cfg #(
  parameter int unsigned WINDOW_WIDTH = cfcd_pkg::WINDOW_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfcd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cfcd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [cfcd_pkg::RATE_W-1:0]    rate_o,
  output logic [cfcd_pkg::TOL_W-1:0]     tol_o,
  output logic [WINDOW_WIDTH-1:0]        win_len_o,
  output logic                           busy_o,
  output logic                           clear_o
);
  import cfcd_pkg::*;

  localparam int unsigned RPROD_W = RATE_W + RECIP_W;
  localparam logic [1:0]  SETTLE_CYCLES = 2'd2;

  logic [RATE_W-1:0]       rate_q;
  logic [WIN_REG_W-1:0]    winreg_q;
  logic [TOL_W-1:0]        tol_q;
  logic [RPROD_W-1:0]      rprod_q;
  logic [WINDOW_WIDTH-1:0] win_len_q, win_len_d;
  logic [1:0]              settle_q;
  logic                    win_write;
  logic [63:0]             derived, chosen, win_max;

  assign win_write = cfg_we_i &&
                     (cfg_index_i == REG_SAMPLE_RATE || cfg_index_i == REG_WINDOW);

  always_comb begin
    derived   = 64'(rprod_q >> RECIP_SHIFT);
    chosen    = (winreg_q != '0) ? 64'(winreg_q) : derived;
    win_max   = (64'd1 << WINDOW_WIDTH) - 64'd1;
    win_len_d = (chosen > win_max) ? win_max[WINDOW_WIDTH-1:0] : chosen[WINDOW_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q    <= RATE_RESET;
      winreg_q  <= WINDOW_RESET;
      tol_q     <= TOL_RESET;
      win_len_q <= '0;
      settle_q  <= SETTLE_CYCLES;
    end else begin
      win_len_q <= win_len_d;
      if (win_write) begin
        settle_q <= SETTLE_CYCLES;
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SAMPLE_RATE: rate_q   <= cfg_data_i[RATE_W-1:0];
          REG_WINDOW:      winreg_q <= cfg_data_i[WIN_REG_W-1:0];
          REG_TOLERANCE:   tol_q    <= cfg_data_i[TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // reciprocal product, registered in the cycle before the window length
  always_ff @(posedge clk_i) begin
    rprod_q <= RPROD_W'(rate_q) * RPROD_W'(RATE_RECIP);
  end

  assign rate_o    = rate_q;
  assign tol_o     = tol_q;
  assign win_len_o = win_len_q;
  assign busy_o    = settle_q != 2'd0;
  assign clear_o   = win_write;

endmodule

`default_nettype wire

// File: rtl/cfcd_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cfcd_fifo #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = cfcd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  import cfcd_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = count_q == CNT_W'(DEPTH);
  assign empty_o = count_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_next(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_next(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH)) else $error("queue count beyond depth");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("queue count did not follow push");

endmodule

`default_nettype wire

// File: rtl/cfcd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module cfcd_front #(
  parameter int unsigned INDEX_WIDTH  = cfcd_pkg::INDEX_WIDTH_DEF,
  parameter int unsigned WINDOW_WIDTH = cfcd_pkg::WINDOW_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic signed [cfcd_pkg::SAMPLE_W-1:0] sample_i,
  input  logic [INDEX_WIDTH-1:0]              sample_index_i,
  input  logic [WINDOW_WIDTH-1:0]             win_len_i,
  input  logic                                cfg_busy_i,
  input  logic                                cfg_clear_i,
  input  logic                                q_full_i,
  output logic                                q_push_o,
  output logic                                job_clr_o,
  output logic [WINDOW_WIDTH-1:0]             job_edges_o,
  output logic [INDEX_WIDTH-1:0]              job_start_o
);
  import cfcd_pkg::*;

  logic                    prev_q, primed_q;
  logic [WINDOW_WIDTH-1:0] edges_q, fill_q;
  logic [INDEX_WIDTH-1:0]  start_q;

  logic                    accept, level, win_on, win_end, is_clear;
  logic [WINDOW_WIDTH-1:0] edges_n, fill_n;
  logic [INDEX_WIDTH-1:0]  start_n;

  assign in_stall_o = cfg_busy_i | q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign is_clear   = cmd_i == CMD_CLEAR;
  assign win_on     = win_len_i != '0;

  always_comb begin
    level   = sample_i > HIGH_THRESHOLD;
    edges_n = (primed_q && level && !prev_q) ? edges_q + WINDOW_WIDTH'(1) : edges_q;
    start_n = primed_q ? start_q : sample_index_i;
    fill_n  = fill_q + WINDOW_WIDTH'(1);
    win_end = fill_n >= win_len_i;
  end

  // clear transactions travel down the queue so the back end drops its history in order
  assign q_push_o    = accept && (is_clear || (win_on && win_end));
  assign job_clr_o   = is_clear;
  assign job_edges_o = edges_n;
  assign job_start_o = start_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b0;
      primed_q <= 1'b0;
      edges_q  <= '0;
      fill_q   <= '0;
      start_q  <= '0;
    end else if (cfg_clear_i || (accept && is_clear)) begin
      prev_q   <= 1'b0;
      primed_q <= 1'b0;
      edges_q  <= '0;
      fill_q   <= '0;
      start_q  <= '0;
    end else if (accept && win_on) begin
      primed_q <= 1'b1;
      prev_q   <= level;
      if (win_end) begin
        edges_q <= '0;
        fill_q  <= '0;
        start_q <= sample_index_i + INDEX_WIDTH'(1);
      end else begin
        edges_q <= edges_n;
        fill_q  <= fill_n;
        start_q <= start_n;
      end
    end
  end

  a_fill_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (win_len_i != '0) |-> fill_q < win_len_i) else $error("window fill past length");
  a_edges_le_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edges_q <= fill_q) else $error("more edges than samples in window");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_full_i) else $error("push into full queue");

endmodule

`default_nettype wire

// File: rtl/cfcd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module cfcd_back #(
  parameter int unsigned INDEX_WIDTH  = cfcd_pkg::INDEX_WIDTH_DEF,
  parameter int unsigned WINDOW_WIDTH = cfcd_pkg::WINDOW_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  logic                          job_clr_i,
  input  logic [WINDOW_WIDTH-1:0]       job_edges_i,
  input  logic [INDEX_WIDTH-1:0]        job_start_i,
  input  logic [cfcd_pkg::RATE_W-1:0]   rate_i,
  input  logic [cfcd_pkg::TOL_W-1:0]    tol_i,
  input  logic [WINDOW_WIDTH-1:0]       win_len_i,
  input  logic                          cfg_clear_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [INDEX_WIDTH-1:0]        window_start_o,
  output logic [cfcd_pkg::FREQ_W-1:0]   frequency_q8_o
);
  import cfcd_pkg::*;

  localparam int unsigned PROD_W = WINDOW_WIDTH + RATE_W;
  localparam int unsigned NUM_W  = PROD_W + FRAC_BITS;
  localparam int unsigned CNT_W  = $clog2(NUM_W + 1);
  localparam int unsigned TP_W   = TOL_W + FREQ_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;

  logic [2:0]              state_q;
  logic [FREQ_W-1:0]       rep_q;
  logic                    est_q;
  logic                    out_valid_q;

  logic [WINDOW_WIDTH-1:0] edges_q;
  logic [INDEX_WIDTH-1:0]  start_q;
  logic [NUM_W-1:0]        num_q, quo_q;
  logic [WINDOW_WIDTH-1:0] rem_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [FREQ_W-1:0]       freq_q, diff_q;
  logic [TP_W-1:0]         tprod_q;
  logic [INDEX_WIDTH-1:0]  out_start_q;
  logic [FREQ_W-1:0]       out_freq_q;

  logic [PROD_W-1:0]       prod;
  logic [WINDOW_WIDTH:0]   rem_sh, rem_sub;
  logic                    ge;
  logic [FREQ_W-1:0]       fsat;
  logic                    report, slot_free, load, hist_clr;

  always_comb begin
    prod    = PROD_W'(edges_q) * PROD_W'(rate_i);
    rem_sh  = {rem_q, num_q[NUM_W-1]};
    ge      = rem_sh >= {1'b0, win_len_i};
    rem_sub = ge ? rem_sh - {1'b0, win_len_i} : rem_sh;
    fsat    = (quo_q > NUM_W'(FREQ_MAX)) ? FREQ_MAX : quo_q[FREQ_W-1:0];
    // the first result and stopped or started clocks always report; otherwise compare against tolerance
    report  = !est_q || ((freq_q != '0) != (rep_q != '0)) ||
              ((rep_q != '0) && ({diff_q, 16'b0} > tprod_q));
  end

  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load      = (state_q == ST_DEC) && report && slot_free;
  assign hist_clr  = cfg_clear_i || (q_pop_o && job_clr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rep_q       <= '0;
      est_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (hist_clr) begin
        rep_q <= '0;
        est_q <= 1'b0;
      end else if (load) begin
        rep_q <= freq_q;
        est_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o && !job_clr_i) state_q <= ST_MUL;
        end
        ST_MUL: begin
          cnt_q   <= CNT_W'(NUM_W);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) state_q <= ST_CMP;
        end
        ST_CMP: begin
          state_q <= ST_DEC;
        end
        ST_DEC: begin
          if (!report || slot_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      edges_q <= job_edges_i;
      start_q <= job_start_i;
    end
    if (state_q == ST_MUL) begin
      num_q <= {prod, FRAC_BITS'(0)};
      quo_q <= '0;
      rem_q <= '0;
    end
    // restoring division, one quotient bit per cycle
    if (state_q == ST_DIV) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_sub[WINDOW_WIDTH-1:0];
    end
    if (state_q == ST_CMP) begin
      freq_q  <= fsat;
      diff_q  <= (fsat >= rep_q) ? fsat - rep_q : rep_q - fsat;
      tprod_q <= TP_W'(tol_i) * TP_W'(rep_q);
    end
    if (load) begin
      out_start_q <= start_q;
      out_freq_q  <= freq_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_start_o = out_start_q;
  assign frequency_q8_o = out_freq_q;

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (win_len_i != '0) && (cnt_q != '0))
    else $error("division with zero divisor or spent counter");
  a_est_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(est_q) |-> out_valid_q) else $error("history set without a result");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> ($past(job_clr_i) ? state_q == ST_IDLE : state_q == ST_MUL))
    else $error("back end left idle on wrong job type");

endmodule

`default_nettype wire
